FILE: hdl/assert_macros.svh
// Assertion helpers used by the scheduler module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mlfq_pkg.sv
`default_nettype none
package mlfq_pkg;
    localparam int MAX_TASKS = 16;
    localparam int TW = $clog2(MAX_TASKS);
    localparam int LW = TW + 1;
    localparam logic [LW-1:0] NIL = LW'(MAX_TASKS);

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_DISPATCH = 3'd1;
    localparam logic [2:0] EV_FINISH   = 3'd2;
    localparam logic [2:0] EV_BLOCK    = 3'd3;
    localparam logic [2:0] EV_DEMOTE   = 3'd4;
    localparam logic [2:0] EV_ADMIT    = 3'd5;
    localparam logic [2:0] EV_REJECT   = 3'd6;

    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_BLOCKED = 2'd3;

    localparam logic [1:0] BLK_LIST = 2'd3;

    localparam logic CFG_Q0 = 1'b0;
    localparam logic CFG_Q1 = 1'b1;

    typedef struct packed {
        logic [2:0]    event_code;
        logic [TW-1:0] event_task;
        logic          cpu_busy;
        logic [TW-1:0] running_task;
        logic [4:0]    woken_count;
        logic          any_active;
    } result_t;

    // Packed from the top bit down, so req_type sits in bit 0
    typedef struct packed {
        logic [7:0]  priority_level;
        logic [15:0] io_duration;
        logic [15:0] burst_length;
        logic [15:0] cpu_demand;
        logic [3:0]  task_id;
        logic        req_type;
    } request_t;
endpackage
`default_nettype wire

FILE: hdl/multilevel_feedback_queue_scheduler.sv
// Three-level feedback scheduler over 16 task slots.
// s_axis: one request per transaction. tuser = req_type (0 admit, 1 tick),
//   tdata = task_id, cpu_demand, burst_length, io_duration, priority_level.
// m_axis: exactly one result per request in tdata.
// cfg: write quantum_level0 (index 0) or quantum_level1 (index 1).
// Steps: a rejected admit goes straight to its result; an accepted admit
//   walks level 0 for its insert point (at most 16 entries), then links it.
//   A tick reads and updates each blocked-list entry and appends each task
//   it wakes, then runs the CPU step, plus a dispatch or tail-append step
//   when a task is dispatched, blocks or is demoted. Each request is
//   finished before the next one is taken.
// s_axis_tready is low while a request is in progress and while a
//   finished result waits in the output register with tready low.
// Reset: all slots free, all lists empty, no task running, quanta 6 and 12.
// Downstream stall: the result is held; the next request is still taken
//   once the output register has been emptied or is being drained.
`default_nettype none
`include "assert_macros.svh"
module multilevel_feedback_queue_scheduler
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: task_id[3:0], cpu_demand[19:4], burst_length[35:20],
    //        io_duration[51:36], priority_level[59:52], zero[63:60]
    input  wire logic [63:0] s_axis_tdata,
    // tuser: req_type[0]
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: event_code[2:0], event_task[6:3], cpu_busy[7], running_task[11:8],
    //        woken_count[16:12], any_active[17], zero[23:18]
    output logic [23:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int TW = mlfq_pkg::TW;
    localparam int LW = mlfq_pkg::LW;
    localparam int N  = mlfq_pkg::MAX_TASKS;

    typedef enum logic [3:0] {
        S_IDLE, S_ADM_WALK, S_ADM_LINK, S_AGE_RD, S_AGE_UPD, S_AGE_APP,
        S_CPU, S_CPU_APP, S_DISPATCH, S_DONE
    } state_t;

    state_t state_reg;

    // per-slot tables (undefined until admitted; status resets to free)
    logic [15:0] remaining_mem [N];
    logic [15:0] burst_lim_mem [N];
    logic [15:0] io_lim_mem    [N];
    logic [7:0]  key_mem       [N];
    logic [15:0] burst_prog_mem[N];
    logic [15:0] io_prog_mem   [N];
    logic [1:0]  origin_mem    [N];
    logic [LW-1:0] link_mem    [N];
    logic [1:0]  status_reg [N];

    logic [LW-1:0] head_reg [4];
    logic [LW-1:0] tail_reg [4];
    logic [LW-1:0] cur_task_reg;
    logic [15:0]   slice_reg;
    logic [15:0]   q0_reg, q1_reg;

    mlfq_pkg::request_t req_reg;
    logic [LW-1:0] prev_reg, walk_reg, nxt_reg;
    logic [4:0]    woken_reg, guard_reg;
    logic [2:0]    code_reg;
    logic [TW-1:0] etask_reg;
    logic [1:0]    app_list_reg;
    logic [TW-1:0] app_task_reg;
    state_t        ret_reg;

    logic          out_full, out_load;
    mlfq_pkg::result_t res;

    logic take;
    logic blk_hit;
    logic [TW-1:0] wt, ct, rid;
    logic [15:0] io_inc, rem_dec, bp_inc, slice_inc, qsel;

    assign take = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !out_full;
    assign cfg_ready = 1'b1;
    assign wt  = walk_reg[TW-1:0];
    assign ct  = cur_task_reg[TW-1:0];
    assign rid = req_reg.task_id[TW-1:0];
    assign io_inc = (io_prog_mem[wt] != 16'hFFFF) ? io_prog_mem[wt] + 16'd1
                                                 : io_prog_mem[wt];
    assign rem_dec = (remaining_mem[ct] != 16'd0) ? remaining_mem[ct] - 16'd1 : 16'd0;
    assign bp_inc = burst_prog_mem[ct] + 16'd1;
    assign slice_inc = slice_reg + 16'd1;
    assign qsel = (origin_mem[ct] == 2'd0) ? q0_reg :
                  (origin_mem[ct] == 2'd1) ? q1_reg : 16'd0;
    assign blk_hit = (rem_dec != 16'd0) && (burst_lim_mem[ct] != 16'd0) &&
                     (bp_inc == burst_lim_mem[ct]);

    always_comb
    begin
        res.event_code   = code_reg;
        res.event_task   = etask_reg;
        res.cpu_busy     = cur_task_reg != mlfq_pkg::NIL;
        res.running_task = res.cpu_busy ? ct : '0;
        res.woken_count  = woken_reg;
        res.any_active   = res.cpu_busy || head_reg[0] != mlfq_pkg::NIL ||
                           head_reg[1] != mlfq_pkg::NIL || head_reg[2] != mlfq_pkg::NIL ||
                           head_reg[3] != mlfq_pkg::NIL;
    end
    assign out_load = (state_reg == S_DONE);

    // Sequencer: steps through each request, updating the slot tables and lists
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < N; i++) status_reg[i] <= mlfq_pkg::ST_FREE;
            for (int l = 0; l < 4; l++)
            begin
                head_reg[l] <= mlfq_pkg::NIL;
                tail_reg[l] <= mlfq_pkg::NIL;
            end
            cur_task_reg <= mlfq_pkg::NIL;
            slice_reg <= '0;
            q0_reg <= 16'd6;
            q1_reg <= 16'd12;
            code_reg <= mlfq_pkg::EV_NONE;
            etask_reg <= '0;
            woken_reg <= '0;
            ret_reg <= S_IDLE;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == mlfq_pkg::CFG_Q0) q0_reg <= cfg_data;
                else q1_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        req_reg <= {s_axis_tdata[59:0], s_axis_tuser};
                        woken_reg <= '0;
                        etask_reg <= s_axis_tuser ? '0 : s_axis_tdata[TW-1:0];
                        if (!s_axis_tuser)
                        begin
                            if (status_reg[s_axis_tdata[TW-1:0]] != mlfq_pkg::ST_FREE)
                            begin
                                code_reg <= mlfq_pkg::EV_REJECT;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                code_reg <= mlfq_pkg::EV_NONE;
                                prev_reg <= mlfq_pkg::NIL;
                                walk_reg <= head_reg[0];
                                guard_reg <= '0;
                                state_reg <= S_ADM_WALK;
                            end
                        end
                        else
                        begin
                            code_reg <= mlfq_pkg::EV_NONE;
                            prev_reg <= mlfq_pkg::NIL;
                            walk_reg <= head_reg[mlfq_pkg::BLK_LIST];
                            guard_reg <= '0;
                            state_reg <= S_AGE_RD;
                        end
                    end
                end
                // Walk level 0 for the insert point
                S_ADM_WALK:
                begin
                    if (walk_reg != mlfq_pkg::NIL && guard_reg < 5'(N) &&
                        key_mem[wt] <= req_reg.priority_level)
                    begin
                        prev_reg <= walk_reg;
                        walk_reg <= link_mem[wt];
                        guard_reg <= guard_reg + 5'd1;
                    end
                    else
                    begin
                        state_reg <= S_ADM_LINK;
                    end
                end
                S_ADM_LINK:
                begin
                    remaining_mem[rid] <= req_reg.cpu_demand;
                    burst_lim_mem[rid] <= req_reg.burst_length;
                    io_lim_mem[rid] <= req_reg.io_duration;
                    key_mem[rid] <= req_reg.priority_level;
                    burst_prog_mem[rid] <= '0;
                    io_prog_mem[rid] <= '0;
                    origin_mem[rid] <= 2'd0;
                    status_reg[rid] <= mlfq_pkg::ST_READY;
                    link_mem[rid] <= walk_reg;
                    if (prev_reg == mlfq_pkg::NIL) head_reg[0] <= LW'(rid);
                    else link_mem[prev_reg[TW-1:0]] <= LW'(rid);
                    if (walk_reg == mlfq_pkg::NIL) tail_reg[0] <= LW'(rid);
                    code_reg <= mlfq_pkg::EV_ADMIT;
                    state_reg <= S_DONE;
                end
                // Age the blocked list one entry per visit
                S_AGE_RD:
                begin
                    if (walk_reg != mlfq_pkg::NIL && guard_reg < 5'(N))
                    begin
                        nxt_reg <= link_mem[wt];
                        guard_reg <= guard_reg + 5'd1;
                        state_reg <= S_AGE_UPD;
                    end
                    else
                    begin
                        state_reg <= S_CPU;
                    end
                end
                S_AGE_UPD:
                begin
                    if (io_inc >= io_lim_mem[wt])
                    begin
                        if (prev_reg == mlfq_pkg::NIL) head_reg[mlfq_pkg::BLK_LIST] <= nxt_reg;
                        else link_mem[prev_reg[TW-1:0]] <= nxt_reg;
                        if (tail_reg[mlfq_pkg::BLK_LIST] == walk_reg)
                            tail_reg[mlfq_pkg::BLK_LIST] <= prev_reg;
                        status_reg[wt] <= mlfq_pkg::ST_READY;
                        io_prog_mem[wt] <= '0;
                        woken_reg <= woken_reg + 5'd1;
                        app_list_reg <= (origin_mem[wt] <= 2'd1) ? origin_mem[wt] : 2'd2;
                        app_task_reg <= wt;
                        ret_reg <= S_AGE_RD;
                        state_reg <= S_AGE_APP;
                    end
                    else
                    begin
                        io_prog_mem[wt] <= io_inc;
                        prev_reg <= walk_reg;
                        state_reg <= S_AGE_RD;
                    end
                    walk_reg <= nxt_reg;
                end
                // Append one slot at a list tail (shared by wake, block, demote)
                S_AGE_APP, S_CPU_APP:
                begin
                    link_mem[app_task_reg] <= mlfq_pkg::NIL;
                    if (head_reg[app_list_reg] == mlfq_pkg::NIL)
                        head_reg[app_list_reg] <= LW'(app_task_reg);
                    else
                        link_mem[tail_reg[app_list_reg][TW-1:0]] <= LW'(app_task_reg);
                    tail_reg[app_list_reg] <= LW'(app_task_reg);
                    state_reg <= (state_reg == S_AGE_APP) ? ret_reg : S_DONE;
                end
                S_CPU:
                begin
                    if (cur_task_reg == mlfq_pkg::NIL)
                    begin
                        // Pick the highest non-empty level
                        if (head_reg[0] != mlfq_pkg::NIL)
                        begin
                            walk_reg <= head_reg[0];
                            app_list_reg <= 2'd0;
                            state_reg <= S_DISPATCH;
                        end
                        else if (head_reg[1] != mlfq_pkg::NIL)
                        begin
                            walk_reg <= head_reg[1];
                            app_list_reg <= 2'd1;
                            state_reg <= S_DISPATCH;
                        end
                        else if (head_reg[2] != mlfq_pkg::NIL)
                        begin
                            walk_reg <= head_reg[2];
                            app_list_reg <= 2'd2;
                            state_reg <= S_DISPATCH;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        remaining_mem[ct] <= rem_dec;
                        burst_prog_mem[ct] <= blk_hit ? 16'd0 : bp_inc;
                        slice_reg <= slice_inc;
                        if (rem_dec == 16'd0)
                        begin
                            status_reg[ct] <= mlfq_pkg::ST_FREE;
                            cur_task_reg <= mlfq_pkg::NIL;
                            code_reg <= mlfq_pkg::EV_FINISH;
                            etask_reg <= ct;
                            state_reg <= S_DONE;
                        end
                        else if (blk_hit)
                        begin
                            status_reg[ct] <= mlfq_pkg::ST_BLOCKED;
                            cur_task_reg <= mlfq_pkg::NIL;
                            code_reg <= mlfq_pkg::EV_BLOCK;
                            etask_reg <= ct;
                            app_list_reg <= mlfq_pkg::BLK_LIST;
                            app_task_reg <= ct;
                            ret_reg <= S_DONE;
                            state_reg <= S_CPU_APP;
                        end
                        else if (qsel != 16'd0 && slice_inc == qsel)
                        begin
                            status_reg[ct] <= mlfq_pkg::ST_READY;
                            cur_task_reg <= mlfq_pkg::NIL;
                            code_reg <= mlfq_pkg::EV_DEMOTE;
                            etask_reg <= ct;
                            app_list_reg <= (origin_mem[ct] == 2'd0) ? 2'd1 : 2'd2;
                            app_task_reg <= ct;
                            ret_reg <= S_DONE;
                            state_reg <= S_CPU_APP;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                // Dispatch: pop the chosen head and start it
                S_DISPATCH:
                begin
                    head_reg[app_list_reg] <= link_mem[wt];
                    if (link_mem[wt] == mlfq_pkg::NIL) tail_reg[app_list_reg] <= mlfq_pkg::NIL;
                    origin_mem[wt] <= app_list_reg;
                    status_reg[wt] <= mlfq_pkg::ST_RUNNING;
                    cur_task_reg <= walk_reg;
                    slice_reg <= '0;
                    code_reg <= mlfq_pkg::EV_DISPATCH;
                    etask_reg <= wt;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    mlfq_outbuf u_outbuf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .load_data     (res),
        .full          (out_full),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `ASSERT_IMPL(a_busy_only_idle, clk, rst_n, s_axis_tready, state_reg == S_IDLE,
                 "input accepted while busy")
    `ASSERT_NEXT(a_done_loads, clk, rst_n, state_reg == S_DONE, m_axis_tvalid,
                 "result not presented")
    `ASSERT_IMPL(a_woken_bound, clk, rst_n, 1'b1, woken_reg <= 5'(N),
                 "woken count too large")
endmodule
`default_nettype wire

FILE: hdl/mlfq_outbuf.sv
`default_nettype none
module mlfq_outbuf
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire mlfq_pkg::result_t load_data,
    output logic                   full,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [23:0]            m_axis_tdata
);
    logic              valid_reg;
    mlfq_pkg::result_t data_reg;

    // Hold one result until the downstream transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign full = valid_reg && !m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata = {6'd0, data_reg.any_active, data_reg.woken_count,
                           data_reg.running_task, data_reg.cpu_busy,
                           data_reg.event_task, data_reg.event_code};
endmodule
`default_nettype wire

FILE: dv/tb_multilevel_feedback_queue_scheduler.sv
`timescale 1ns / 100ps
module tb_multilevel_feedback_queue_scheduler;
    localparam int LIMIT_CYCLES = 1000000;

    typedef struct {
        logic [2:0]  code;
        logic [3:0]  etask;
        logic        busy;
        logic [3:0]  running;
        logic [4:0]  woken;
        logic        active;
    } sched_event_t;

    typedef struct {
        logic        tick;
        logic [63:0] data;
    } request_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    multilevel_feedback_queue_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Scheduler shadow state
    logic [1:0]  slot_st [mlfq_pkg::MAX_TASKS];
    logic [15:0] rem_units [mlfq_pkg::MAX_TASKS];
    logic [15:0] burst_cap [mlfq_pkg::MAX_TASKS];
    logic [15:0] io_cap [mlfq_pkg::MAX_TASKS];
    logic [7:0]  prio_key [mlfq_pkg::MAX_TASKS];
    logic [15:0] burst_used [mlfq_pkg::MAX_TASKS];
    logic [15:0] io_waited [mlfq_pkg::MAX_TASKS];
    logic [1:0]  home_level [mlfq_pkg::MAX_TASKS];
    logic [4:0]  link [mlfq_pkg::MAX_TASKS];
    logic [4:0]  lhead [4];
    logic [4:0]  ltail [4];
    logic [4:0]  on_cpu;
    logic [15:0] slice_used;
    logic [15:0] quantum0;
    logic [15:0] quantum1;

    request_word_t pending_reqs[$];
    sched_event_t  expected_events[$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_cycles = 0;
    int  cycle_count = 0;
    int  fail_count = 0;
    int  admits_sent = 0;
    int  ticks_sent = 0;
    int  events_seen = 0;
    bit  s_taken = 1'b0;

    task automatic queue_append(input logic [1:0] l, input logic [4:0] t);
        link[t[3:0]] = mlfq_pkg::NIL;
        if (lhead[l] == mlfq_pkg::NIL)
            lhead[l] = t;
        else
            link[ltail[l][3:0]] = t;
        ltail[l] = t;
    endtask

    task automatic level0_sorted_insert(input logic [4:0] t);
        logic [4:0] prev;
        logic [4:0] c;
        int guard;
        prev = mlfq_pkg::NIL;
        c = lhead[0];
        guard = 0;
        while (c != mlfq_pkg::NIL && guard < mlfq_pkg::MAX_TASKS &&
               prio_key[c[3:0]] <= prio_key[t[3:0]])
        begin
            prev = c;
            c = link[c[3:0]];
            guard++;
        end
        link[t[3:0]] = c;
        if (prev == mlfq_pkg::NIL)
            lhead[0] = t;
        else
            link[prev[3:0]] = t;
        if (c == mlfq_pkg::NIL)
            ltail[0] = t;
    endtask

    task automatic age_io_waiters(output logic [4:0] woken);
        logic [4:0] prev;
        logic [4:0] c;
        logic [4:0] n;
        logic [1:0] lv;
        int guard;
        prev = mlfq_pkg::NIL;
        c = lhead[mlfq_pkg::BLK_LIST];
        woken = '0;
        guard = 0;
        while (c != mlfq_pkg::NIL && guard < mlfq_pkg::MAX_TASKS)
        begin
            n = link[c[3:0]];
            guard++;
            if (io_waited[c[3:0]] != 16'hFFFF)
                io_waited[c[3:0]]++;
            if (io_waited[c[3:0]] >= io_cap[c[3:0]])
            begin
                lv = home_level[c[3:0]];
                if (prev == mlfq_pkg::NIL)
                    lhead[mlfq_pkg::BLK_LIST] = n;
                else
                    link[prev[3:0]] = n;
                if (ltail[mlfq_pkg::BLK_LIST] == c)
                    ltail[mlfq_pkg::BLK_LIST] = prev;
                slot_st[c[3:0]] = mlfq_pkg::ST_READY;
                io_waited[c[3:0]] = '0;
                queue_append((lv <= 2'd1) ? lv : 2'd2, c);
                woken++;
            end
            else
                prev = c;
            c = n;
        end
    endtask

    // Advance the shadow scheduler by one request and return its event
    task automatic schedule_request(input logic tick, input logic [63:0] d,
                                    output sched_event_t ev);
        logic [3:0]  id;
        logic [4:0]  t;
        logic [15:0] q;
        logic [4:0]  woken;
        ev = '{default: '0};
        woken = '0;
        if (!tick)
        begin
            id = d[3:0];
            ev.etask = id;
            if (slot_st[id] != mlfq_pkg::ST_FREE)
                ev.code = mlfq_pkg::EV_REJECT;
            else
            begin
                rem_units[id] = d[19:4];
                burst_cap[id] = d[35:20];
                io_cap[id] = d[51:36];
                prio_key[id] = d[59:52];
                burst_used[id] = '0;
                io_waited[id] = '0;
                home_level[id] = 2'd0;
                slot_st[id] = mlfq_pkg::ST_READY;
                level0_sorted_insert({1'b0, id});
                ev.code = mlfq_pkg::EV_ADMIT;
            end
        end
        else
        begin
            age_io_waiters(woken);
            if (on_cpu == mlfq_pkg::NIL)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    if (ev.code == mlfq_pkg::EV_NONE && lhead[l] != mlfq_pkg::NIL)
                    begin
                        t = lhead[l];
                        lhead[l] = link[t[3:0]];
                        if (lhead[l] == mlfq_pkg::NIL)
                            ltail[l] = mlfq_pkg::NIL;
                        home_level[t[3:0]] = l[1:0];
                        slot_st[t[3:0]] = mlfq_pkg::ST_RUNNING;
                        on_cpu = t;
                        slice_used = '0;
                        ev.code = mlfq_pkg::EV_DISPATCH;
                        ev.etask = t[3:0];
                    end
                end
            end
            else
            begin
                t = on_cpu;
                if (rem_units[t[3:0]] != 0)
                    rem_units[t[3:0]]--;
                burst_used[t[3:0]]++;
                slice_used++;
                q = (home_level[t[3:0]] == 2'd0) ? quantum0 :
                    (home_level[t[3:0]] == 2'd1) ? quantum1 : 16'd0;
                if (rem_units[t[3:0]] == 0)
                begin
                    slot_st[t[3:0]] = mlfq_pkg::ST_FREE;
                    on_cpu = mlfq_pkg::NIL;
                    ev.code = mlfq_pkg::EV_FINISH;
                    ev.etask = t[3:0];
                end
                else if (burst_cap[t[3:0]] != 0 && burst_used[t[3:0]] == burst_cap[t[3:0]])
                begin
                    slot_st[t[3:0]] = mlfq_pkg::ST_BLOCKED;
                    burst_used[t[3:0]] = '0;
                    queue_append(mlfq_pkg::BLK_LIST, t);
                    on_cpu = mlfq_pkg::NIL;
                    ev.code = mlfq_pkg::EV_BLOCK;
                    ev.etask = t[3:0];
                end
                else if (q != 0 && slice_used == q)
                begin
                    slot_st[t[3:0]] = mlfq_pkg::ST_READY;
                    queue_append((home_level[t[3:0]] == 2'd0) ? 2'd1 : 2'd2, t);
                    on_cpu = mlfq_pkg::NIL;
                    ev.code = mlfq_pkg::EV_DEMOTE;
                    ev.etask = t[3:0];
                end
            end
        end
        ev.busy = (on_cpu != mlfq_pkg::NIL);
        ev.running = ev.busy ? on_cpu[3:0] : 4'd0;
        ev.woken = woken;
        ev.active = ev.busy || lhead[0] != mlfq_pkg::NIL || lhead[1] != mlfq_pkg::NIL ||
                    lhead[2] != mlfq_pkg::NIL || lhead[mlfq_pkg::BLK_LIST] != mlfq_pkg::NIL;
    endtask

    task automatic push_admit(input logic [3:0] id, input logic [15:0] demand,
                              input logic [15:0] burst, input logic [15:0] io,
                              input logic [7:0] prio);
        request_word_t r;
        r.tick = 1'b0;
        r.data = {4'b0, prio, io, burst, demand, id};
        pending_reqs.push_back(r);
        admits_sent++;
    endtask

    task automatic push_tick(input logic [63:0] junk);
        request_word_t r;
        r.tick = 1'b1;
        r.data = junk;
        pending_reqs.push_back(r);
        ticks_sent++;
    endtask

    // Mostly ticks, else short tasks with small bursts; now and then full-range fields
    task automatic push_random(input int n);
        logic [15:0] demand;
        logic [15:0] burst;
        logic [15:0] io;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 65)
                push_tick({4'b0, 60'($urandom()) ^ (60'($urandom()) << 30)});
            else
            begin
                demand = 16'($urandom_range(0, 30));
                burst = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
                io = 16'($urandom_range(0, 6));
                if ($urandom_range(19) == 0)
                begin
                    burst = 16'd0;
                    io = 16'($urandom());
                end
                if ($urandom_range(39) == 0)
                begin
                    demand = 16'($urandom());
                    burst = 16'($urandom()) | 16'h8000;
                end
                push_admit(4'($urandom()), demand, burst, io, 8'($urandom()));
            end
        end
    endtask

    task automatic write_quantum(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == mlfq_pkg::CFG_Q0)
            quantum0 = val;
        else
            quantum1 = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_all();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    // Feed requests from the pending queue
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || s_taken)
        begin
            s_taken = 1'b0;
            if (pending_reqs.size() != 0 && rst_n && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tuser <= pending_reqs[0].tick;
                s_axis_tdata <= pending_reqs[0].data;
                s_axis_tvalid <= 1'b1;
                void'(pending_reqs.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Stall the result side, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Predict on each accepted request, check each result transaction
    always @(posedge clk)
    begin
        sched_event_t ev;
        sched_event_t want;
        if (s_axis_tvalid && s_axis_tready)
        begin
            schedule_request(s_axis_tuser, s_axis_tdata, ev);
            expected_events.push_back(ev);
            s_taken = 1'b1;
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            events_seen++;
            if (expected_events.size() == 0)
            begin
                $error("unexpected result transaction tdata=%h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (m_axis_tdata[2:0] != want.code)
                begin
                    $error("event_code exp %0d got %0d", want.code, m_axis_tdata[2:0]);
                    fail_count++;
                end
                if (m_axis_tdata[6:3] != want.etask)
                begin
                    $error("event_task exp %0d got %0d", want.etask, m_axis_tdata[6:3]);
                    fail_count++;
                end
                if (m_axis_tdata[7] != want.busy)
                begin
                    $error("cpu_busy exp %0d got %0d", want.busy, m_axis_tdata[7]);
                    fail_count++;
                end
                if (m_axis_tdata[11:8] != want.running)
                begin
                    $error("running_task exp %0d got %0d", want.running, m_axis_tdata[11:8]);
                    fail_count++;
                end
                if (m_axis_tdata[16:12] != want.woken)
                begin
                    $error("woken_count exp %0d got %0d", want.woken, m_axis_tdata[16:12]);
                    fail_count++;
                end
                if (m_axis_tdata[17] != want.active)
                begin
                    $error("any_active exp %0d got %0d", want.active, m_axis_tdata[17]);
                    fail_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < mlfq_pkg::MAX_TASKS; i++)
        begin
            slot_st[i] = mlfq_pkg::ST_FREE;
            link[i] = mlfq_pkg::NIL;
        end
        for (int l = 0; l < 4; l++)
        begin
            lhead[l] = mlfq_pkg::NIL;
            ltail[l] = mlfq_pkg::NIL;
        end
        on_cpu = mlfq_pkg::NIL;
        slice_used = '0;
        quantum0 = 16'd6;
        quantum1 = 16'd12;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: ordering by key, ties, rejects, zero demand and zero I/O
        push_tick(64'hFFFF_FFFF_FFFF_FFFF);
        push_admit(4'd0, 16'hFFFF, 16'd0, 16'hFFFF, 8'd255);
        push_admit(4'd15, 16'd0, 16'd1, 16'd0, 8'd0);
        push_admit(4'd5, 16'd3, 16'd1, 16'd0, 8'd7);
        push_admit(4'd6, 16'd2, 16'd0, 16'd0, 8'd7);
        push_admit(4'd5, 16'd1, 16'd0, 16'd0, 8'd1);
        push_admit(4'd9, 16'd20, 16'hFFFF, 16'd2, 8'd100);
        push_admit(4'd10, 16'd4, 16'd2, 16'd3, 8'd7);
        repeat (17) push_tick('0);
        drain_all();

        // Phased random traffic over several quanta and idling patterns
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_quantum(mlfq_pkg::CFG_Q0, 16'd1);
                    write_quantum(mlfq_pkg::CFG_Q1, 16'd2);
                end
                1:
                begin
                    write_quantum(mlfq_pkg::CFG_Q0, 16'd0);
                    write_quantum(mlfq_pkg::CFG_Q1, 16'd0);
                end
                2:
                begin
                    write_quantum(mlfq_pkg::CFG_Q0, 16'hFFFF);
                    write_quantum(mlfq_pkg::CFG_Q1, 16'hFFFF);
                end
                3:
                begin
                    write_quantum(mlfq_pkg::CFG_Q0, 16'd3);
                    write_quantum(mlfq_pkg::CFG_Q1, 16'd5);
                end
                4:
                begin
                    write_quantum(mlfq_pkg::CFG_Q0, 16'h5AA5);
                    write_quantum(mlfq_pkg::CFG_Q1, 16'hA55A);
                end
                default:
                begin
                    write_quantum(mlfq_pkg::CFG_Q0, 16'($urandom_range(1, 8)));
                    write_quantum(mlfq_pkg::CFG_Q1, 16'($urandom_range(1, 16)));
                end
            endcase
            send_idle_pct = (ph % 4 == 1) ? 84 : (ph % 4 == 3) ? 29 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 84 : (ph % 4 == 3) ? 29 : 0;
            if (ph == 0)
                hold_cycles = 400;
            push_random(245);
            drain_all();
        end

        $display("sent %0d admits and %0d ticks, checked %0d results",
                 admits_sent, ticks_sent, events_seen);
        $display("quanta swept over 0, 1, small and 65535 with mixed stalls");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: multilevel_feedback_queue_scheduler.f
+incdir+hdl
hdl/mlfq_pkg.sv
hdl/mlfq_outbuf.sv
hdl/multilevel_feedback_queue_scheduler.sv
dv/tb_multilevel_feedback_queue_scheduler.sv
